>>> src/uadf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uadf_pkg
// Shared types, character codes and helper functions for the URL decoder
// with accented letter folding.
// ----------------------------------------------------------------------------
package uadf_pkg;

  localparam int RUN_MAX         = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // raw and decoded byte codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  // utf-8 lead classes
  localparam logic [7:0] LEAD_C3   = 8'hC3;
  localparam logic [7:0] MASK_2B   = 8'hE0;
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] MASK_3B   = 8'hF0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] MASK_4B   = 8'hF8;
  localparam logic [7:0] LEAD_4B   = 8'hF0;

  // folded output letters (upper case; lower case sets bit 5)
  localparam logic [6:0] CH_QUEST  = 7'h3F;
  localparam logic [6:0] CH_A      = 7'h41;
  localparam logic [6:0] CH_C      = 7'h43;
  localparam logic [6:0] CH_E      = 7'h45;
  localparam logic [6:0] CH_I      = 7'h49;
  localparam logic [6:0] CH_N      = 7'h4E;
  localparam logic [6:0] CH_O      = 7'h4F;
  localparam logic [6:0] CH_U      = 7'h55;
  localparam logic [6:0] CH_Y      = 7'h59;
  localparam logic [6:0] LOWER_BIT = 7'h20;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  // decoded bytes of one input item, in order; a NUL only as the final byte
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              cnt;
  } run_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       vld;
    logic       fin;
  } res_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

  // second byte after a 0xC3 lead
  function automatic logic [6:0] c3_letter(logic [7:0] c);
    logic [4:0] lo;
    logic [6:0] base;
    lo = c[4:0];
    if (c[7:6] != 2'b10) begin
      return CH_QUEST;
    end
    if (lo <= 5'h05) begin
      base = CH_A;
    end else if (lo == 5'h07) begin
      base = CH_C;
    end else if (lo >= 5'h08 && lo <= 5'h0B) begin
      base = CH_E;
    end else if (lo >= 5'h0C && lo <= 5'h0F) begin
      base = CH_I;
    end else if (lo == 5'h11) begin
      base = CH_N;
    end else if (lo >= 5'h12 && lo <= 5'h16) begin
      base = CH_O;
    end else if (lo >= 5'h19 && lo <= 5'h1C) begin
      base = CH_U;
    end else if (lo == 5'h1D) begin
      base = CH_Y;
    end else begin
      return CH_QUEST;
    end
    return c[5] ? (base | LOWER_BIT) : base;
  endfunction

endpackage
`default_nettype wire

>>> src/uadf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uadf_front
// Accepts raw bytes, resolves '+' and percent escapes, and hands the decoded
// bytes of each item, if there are any, to the queue as one run.
// ----------------------------------------------------------------------------
module uadf_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  output logic                in_ready,
  input  wire logic           q_full,
  output logic                q_push,
  output uadf_pkg::run_t      q_data
);
  import uadf_pkg::*;

  typedef struct packed {
    run_t run;
    logic closed;
  } acc_t;

  function automatic acc_t app(acc_t a, logic [7:0] d);
    acc_t o;
    o = a;
    if (!a.closed && a.run.cnt < 3'(RUN_MAX)) begin
      o.run.bytes[a.run.cnt[1:0]] = d;
      o.run.cnt                   = a.run.cnt + 3'd1;
      o.closed                    = (d == CH_NUL);
    end
    return o;
  endfunction

  esc_t       esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;
  logic       ended_r, ended_nxt;
  logic       accept;
  logic       do_plain;
  acc_t       acc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_data   = acc.run;

  always_comb begin
    acc       = '0;
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    ended_nxt = ended_r;
    do_plain  = 1'b0;
    q_push    = 1'b0;
    if (accept) begin
      if (ended_r) begin
        // text closed early: drop bytes up to and including the last one
        if (in_last) begin
          ended_nxt = 1'b0;
        end
      end else begin
        unique case (esc_r)
          ESC_PCT: begin
            if (is_hex(in_byte)) begin
              held_nxt = in_byte;
              esc_nxt  = ESC_DIGIT;
            end else begin
              esc_nxt  = ESC_NONE;
              acc      = app(acc, CH_PCT);
              do_plain = 1'b1;
            end
          end
          ESC_DIGIT: begin
            esc_nxt = ESC_NONE;
            if (is_hex(in_byte)) begin
              acc = app(acc, {hex_val(held_r), hex_val(in_byte)});
            end else begin
              acc      = app(acc, CH_PCT);
              acc      = app(acc, held_r);
              do_plain = 1'b1;
            end
          end
          default: begin
            do_plain = 1'b1;
          end
        endcase
        if (do_plain) begin
          if (in_byte == CH_PLUS) begin
            acc = app(acc, CH_SPACE);
          end else if (in_byte == CH_PCT) begin
            esc_nxt = ESC_PCT;
          end else begin
            acc = app(acc, in_byte);
          end
        end
        // flush a pending escape and close the text
        if (in_last && !acc.closed) begin
          if (esc_nxt == ESC_PCT) begin
            acc = app(acc, CH_PCT);
          end else if (esc_nxt == ESC_DIGIT) begin
            acc = app(acc, CH_PCT);
            acc = app(acc, held_nxt);
          end
          esc_nxt = ESC_NONE;
          acc     = app(acc, CH_NUL);
        end
        if (acc.closed) begin
          esc_nxt = ESC_NONE;
        end
        ended_nxt = acc.closed && !in_last;
        q_push    = (acc.run.cnt != 3'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= ESC_NONE;
      held_r  <= 8'h00;
      ended_r <= 1'b0;
    end else begin
      esc_r   <= esc_nxt;
      held_r  <= held_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/uadf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uadf_fifo
// Short register queue of decoded runs between the front and the back.
// ----------------------------------------------------------------------------
module uadf_fifo #(
  parameter int DEPTH = uadf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire uadf_pkg::run_t push_data,
  output logic                full,
  input  wire logic           pop,
  output uadf_pkg::run_t      pop_data,
  output logic                empty
);
  import uadf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  run_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CW'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

>>> src/uadf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uadf_back
// Folds one decoded run per load into up to four results and hands them out
// one per cycle while out_ready is high, from a result buffer.
// ----------------------------------------------------------------------------
module uadf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire uadf_pkg::run_t q_data,
  output logic                q_pop,
  output logic                out_item_valid,
  input  wire logic           out_ready,
  output logic [6:0]          out_char,
  output logic                out_valid,
  output logic                text_end,
  output logic                run_last
);
  import uadf_pkg::*;

  typedef struct packed {
    res_t [RUN_MAX-1:0] r;
    logic [2:0]         n;
  } fold_t;

  function automatic fold_t put(fold_t f, logic [6:0] ch, logic vld, logic fin);
    fold_t o;
    o = f;
    if (f.n < 3'(RUN_MAX)) begin
      o.r[f.n[1:0]] = '{ch: ch, vld: vld, fin: fin};
      o.n           = f.n + 3'd1;
    end
    return o;
  endfunction

  res_t       res_r [RUN_MAX];
  logic       have_r, have_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_r, last_nxt;
  logic       c3_r, c3_nxt;
  logic [1:0] skip_r, skip_nxt;
  logic       can_load;
  fold_t      fo;
  logic       c3;
  logic [1:0] sk;
  logic [7:0] d;

  assign run_last       = (idx_r == last_r);
  assign can_load       = !have_r || (out_ready && run_last);
  assign q_pop          = can_load && !q_empty;
  assign out_item_valid = have_r;
  assign out_char       = res_r[idx_r].ch;
  assign out_valid      = res_r[idx_r].vld;
  assign text_end       = res_r[idx_r].fin;

  // utf-8 fold over the bytes of the run at the queue head
  always_comb begin
    fo = '0;
    c3 = c3_r;
    sk = skip_r;
    d  = 8'h00;
    for (int i = 0; i < RUN_MAX; i++) begin
      if (3'(i) < q_data.cnt) begin
        d = q_data.bytes[i];
        if (d == CH_NUL) begin
          if (c3) begin
            fo = put(fo, CH_QUEST, 1'b1, 1'b0);
          end
          fo = put(fo, 7'h00, 1'b0, 1'b1);
          c3 = 1'b0;
          sk = 2'd0;
        end else if (sk != 2'd0) begin
          sk = sk - 2'd1;
        end else if (c3) begin
          c3 = 1'b0;
          fo = put(fo, c3_letter(d), 1'b1, 1'b0);
        end else if (d == LEAD_C3) begin
          c3 = 1'b1;
        end else if ((d & MASK_2B) == LEAD_2B) begin
          fo = put(fo, CH_QUEST, 1'b1, 1'b0);
          sk = 2'd1;
        end else if ((d & MASK_3B) == LEAD_3B) begin
          fo = put(fo, CH_QUEST, 1'b1, 1'b0);
          sk = 2'd2;
        end else if ((d & MASK_4B) == LEAD_4B) begin
          fo = put(fo, CH_QUEST, 1'b1, 1'b0);
          sk = 2'd3;
        end else if (d >= PRINT_LO && d <= PRINT_HI) begin
          fo = put(fo, d[6:0], 1'b1, 1'b0);
        end
      end
    end
  end

  always_comb begin
    have_nxt = have_r;
    idx_nxt  = idx_r;
    last_nxt = last_r;
    c3_nxt   = c3_r;
    skip_nxt = skip_r;
    if (q_pop) begin
      have_nxt = (fo.n != 3'd0);
      idx_nxt  = 2'd0;
      last_nxt = 2'(fo.n - 3'd1);
      c3_nxt   = c3;
      skip_nxt = sk;
    end else if (can_load) begin
      have_nxt = 1'b0;
    end else if (out_ready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < RUN_MAX; i++) begin
        res_r[i] <= fo.r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= 2'd0;
      last_r <= 2'd0;
      c3_r   <= 1'b0;
      skip_r <= 2'd0;
    end else begin
      have_r <= have_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
      c3_r   <= c3_nxt;
      skip_r <= skip_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && !(out_ready && run_last)) |=> (have_r && $stable(last_r)))
    else $error("result run dropped before its last item");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && text_end) |-> run_last)
    else $error("end marker is not the last item of its run");
`endif

endmodule
`default_nettype wire

>>> src/url_decode_accent_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// url_decode_accent_fold
// URL percent decoder with UTF-8 accented letter folding to printable ASCII.
// ----------------------------------------------------------------------------
// an item's run is registered in the run queue, then in the result buffer, before its first result leaves
// throughput: one item per cycle while the run queue is not full; an item yields
//   up to four results, taken one at a time, and the run queue absorbs the difference
// the output buffer takes the next run in the cycle its last item is taken
// reset: synchronous active low, clears escape, fold and queue state at once
module url_decode_accent_fold #(
  parameter int QUEUE_DEPTH = uadf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_item_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char,
  output logic            out_valid,
  output logic            text_end,
  output logic            run_last
);
  import uadf_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  run_t q_wdata;
  run_t q_rdata;

  uadf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  uadf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  uadf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_item_valid (out_item_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_valid      (out_valid),
    .text_end       (text_end),
    .run_last       (run_last)
  );

endmodule
`default_nettype wire

>>> tb/uadf_fold_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uadf_fold_check
// Watches both channels of the URL decoder, predicts the folded characters
// and end markers of every accepted byte, and compares each result in order.
// ----------------------------------------------------------------------------
module uadf_fold_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       out_item_valid,
  input  wire logic       out_ready,
  input  wire logic [6:0] out_char,
  input  wire logic       out_valid,
  input  wire logic       text_end,
  input  wire logic       run_last,
  output int              mismatches,
  output int              awaiting,
  output int              checked
);
  import uadf_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       printable;
    logic       closes;
    logic       run_end;
  } folded_t;

  folded_t    fold_q[$];
  folded_t    run_buf[$];

  esc_t       esc_state;
  logic [7:0] held_digit;
  logic       c3_pending;
  logic [1:0] skip_cnt;
  logic       text_closed;
  logic       step_done;
  logic       step_final;

  function automatic logic is_hex_char(logic [7:0] c);
    logic [7:0] up;
    up = c & 8'hDF;  // fold lower case letters onto upper case
    return (c >= 8'h30 && c <= 8'h39) || (up >= 8'h41 && up <= 8'h46);
  endfunction

  function automatic logic [3:0] nibble_of(logic [7:0] c);
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic logic [6:0] accent_base(logic [7:0] c);
    logic [6:0] up;
    if (c < 8'h80 || c > 8'hBF) begin
      return CH_QUEST;
    end
    case (c[4:0])
      5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05: up = CH_A;
      5'h07:                                    up = CH_C;
      5'h08, 5'h09, 5'h0A, 5'h0B:               up = CH_E;
      5'h0C, 5'h0D, 5'h0E, 5'h0F:               up = CH_I;
      5'h11:                                    up = CH_N;
      5'h12, 5'h13, 5'h14, 5'h15, 5'h16:        up = CH_O;
      5'h19, 5'h1A, 5'h1B, 5'h1C:               up = CH_U;
      5'h1D:                                    up = CH_Y;
      default:                                  return CH_QUEST;
    endcase
    return (c >= 8'hA0) ? (up | LOWER_BIT) : up;
  endfunction

  task automatic put_char(logic [6:0] ch, logic printable, logic closes);
    folded_t r;
    if (run_buf.size() < RUN_MAX) begin
      r = '{ch, printable, closes, 1'b0};
      run_buf.push_back(r);
    end
  endtask

  task automatic close_text();
    put_char(7'h00, 1'b0, 1'b1);
    esc_state   = ESC_NONE;
    held_digit  = 8'h00;
    c3_pending  = 1'b0;
    skip_cnt    = 2'd0;
    step_done   = 1'b1;
    text_closed = !step_final;
  endtask

  // second stage, one decoded byte
  task automatic fold_byte(logic [7:0] d);
    if (step_done) begin
      return;
    end
    if (d == CH_NUL) begin
      if (c3_pending) begin
        put_char(CH_QUEST, 1'b1, 1'b0);
      end
      close_text();
    end else if (skip_cnt != 2'd0) begin
      skip_cnt = skip_cnt - 2'd1;
    end else if (c3_pending) begin
      c3_pending = 1'b0;
      put_char(accent_base(d), 1'b1, 1'b0);
    end else if (d == LEAD_C3) begin
      c3_pending = 1'b1;
    end else if ((d & MASK_2B) == LEAD_2B) begin
      put_char(CH_QUEST, 1'b1, 1'b0);
      skip_cnt = 2'd1;
    end else if ((d & MASK_3B) == LEAD_3B) begin
      put_char(CH_QUEST, 1'b1, 1'b0);
      skip_cnt = 2'd2;
    end else if ((d & MASK_4B) == LEAD_4B) begin
      put_char(CH_QUEST, 1'b1, 1'b0);
      skip_cnt = 2'd3;
    end else if (d >= PRINT_LO && d <= PRINT_HI) begin
      put_char(d[6:0], 1'b1, 1'b0);
    end
  endtask

  task automatic raw_byte(logic [7:0] b);
    if (b == CH_PLUS) begin
      fold_byte(CH_SPACE);
    end else if (b == CH_PCT) begin
      esc_state = ESC_PCT;
    end else begin
      fold_byte(b);
    end
  endtask

  task automatic decode_item(logic [7:0] b, logic fin);
    folded_t tail;
    if (text_closed) begin
      if (fin) begin
        text_closed = 1'b0;
      end
      return;
    end
    run_buf.delete();
    step_done  = 1'b0;
    step_final = fin;
    case (esc_state)
      ESC_PCT: begin
        if (is_hex_char(b)) begin
          held_digit = b;
          esc_state  = ESC_DIGIT;
        end else begin
          esc_state = ESC_NONE;
          fold_byte(CH_PCT);
          raw_byte(b);
        end
      end
      ESC_DIGIT: begin
        esc_state = ESC_NONE;
        if (is_hex_char(held_digit) && is_hex_char(b)) begin
          fold_byte({nibble_of(held_digit), nibble_of(b)});
        end else begin
          fold_byte(CH_PCT);
          fold_byte(held_digit);
          raw_byte(b);
        end
      end
      default: begin
        raw_byte(b);
      end
    endcase
    // last byte flushes a cut-short escape, then closes the text
    if (fin && !step_done) begin
      if (esc_state == ESC_PCT) begin
        esc_state = ESC_NONE;
        fold_byte(CH_PCT);
      end else if (esc_state == ESC_DIGIT) begin
        esc_state = ESC_NONE;
        fold_byte(CH_PCT);
        fold_byte(held_digit);
      end
      fold_byte(CH_NUL);
    end
    if (run_buf.size() > 0) begin
      tail = run_buf.pop_back();
      tail.run_end = 1'b1;
      run_buf.push_back(tail);
    end
    foreach (run_buf[i]) begin
      fold_q.push_back(run_buf[i]);
    end
  endtask

  task automatic check_field(string what, logic [6:0] want_v, logic [6:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    folded_t want;
    if (!rst_n) begin
      esc_state   = ESC_NONE;
      held_digit  = 8'h00;
      c3_pending  = 1'b0;
      skip_cnt    = 2'd0;
      text_closed = 1'b0;
      fold_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_item(in_byte, in_last);
      end
      if (out_item_valid && out_ready) begin
        checked++;
        if (fold_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got char %h valid %b end %b last %b",
                   $time, out_char, out_valid, text_end, run_last);
          mismatches++;
        end else begin
          want = fold_q.pop_front();
          check_field("out_char", want.ch, out_char);
          check_field("out_valid", 7'(want.printable), 7'(out_valid));
          check_field("text_end", 7'(want.closes), 7'(text_end));
          check_field("run_last", 7'(want.run_end), 7'(run_last));
        end
      end
    end
    awaiting = fold_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives URL-encoded texts into the decoder with random idle and stall
// bursts; the fold checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import uadf_pkg::*;

  localparam int RANDOM_ITEMS = 256;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h20;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       gaps_on   = 1'b0;
  logic       stalls_on = 1'b0;

  wire logic       in_ready;
  wire logic       out_item_valid;
  wire logic [6:0] out_char;
  wire logic       out_valid;
  wire logic       text_end;
  wire logic       run_last;

  int mismatches;
  int awaiting;
  int checked;
  int items_sent = 0;
  int texts_sent = 0;
  int cycle_cnt  = 0;

  logic [7:0] text_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  url_decode_accent_fold dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_item_valid (out_item_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_valid      (out_valid),
    .text_end       (text_end),
    .run_last       (run_last)
  );

  uadf_fold_check fold_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_item_valid (out_item_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_valid      (out_valid),
    .text_end       (text_end),
    .run_last       (run_last),
    .mismatches     (mismatches),
    .awaiting       (awaiting),
    .checked        (checked)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("url_decode_accent_fold verification failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  always begin : sink
    @(negedge clk);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    texts_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return (upper ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  task automatic push_escape(logic [7:0] v);
    text_q.push_back(CH_PCT);
    text_q.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
    text_q.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic push_maybe_escaped(logic [7:0] v);
    if ($urandom_range(0, 3) == 0) begin
      push_escape(v);
    end else begin
      text_q.push_back(v);
    end
  endtask

  task automatic add_token();
    logic [7:0] v;
    int         kind;
    int         n;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2: begin
        v = 8'($urandom_range(32, 126));
        text_q.push_back(v);
      end
      3: begin
        text_q.push_back(CH_PLUS);
      end
      4, 5: begin
        // a decoded nul now and then closes the text early
        v = ($urandom_range(0, 24) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        push_escape(v);
      end
      6: begin
        push_maybe_escaped(LEAD_C3);
        v = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                        : 8'($urandom_range(1, 255));
        push_maybe_escaped(v);
      end
      7: begin
        push_escape(LEAD_C3);
        v = 8'($urandom_range(8'h80, 8'hBF));
        push_escape(v);
      end
      8: begin
        n = $urandom_range(1, 3);
        case (n)
          1:       v = 8'hC0 + 8'($urandom_range(0, 31));
          2:       v = 8'hE0 + 8'($urandom_range(0, 15));
          default: v = 8'hF0 + 8'($urandom_range(0, 7));
        endcase
        if (v == LEAD_C3) begin
          v = 8'hC2;
        end
        push_maybe_escaped(v);
        repeat (n) begin
          v = 8'h80 + 8'($urandom_range(0, 63));
          push_maybe_escaped(v);
        end
      end
      9: begin
        // escape broken by a non-hex byte
        text_q.push_back(CH_PCT);
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        v = ($urandom_range(0, 1) == 1) ? 8'h47 + 8'($urandom_range(0, 19))
                                        : 8'h80 + 8'($urandom_range(0, 127));
        text_q.push_back(v);
      end
      10: begin
        v = 8'($urandom_range(1, 255));
        text_q.push_back(v);
      end
      default: begin
        v = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 31))
                                        : 8'($urandom_range(127, 255));
        text_q.push_back(v);
      end
    endcase
  endtask

  initial begin : stimulus
    int  start;
    int  done_cnt;
    logic paused;
    paused = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // plus, escape of a letter
    text_q = '{8'h2B, 8'h25, 8'h34, 8'h31};
    send_text();
    // accented letters, dropped byte, lead at the end
    text_q = '{8'hC3, 8'hA7, 8'hC3, 8'h91, 8'hFF, 8'hC3};
    send_text();
    // skipped sequences, cut escape whose percent falls into a skip
    text_q = '{8'hE2, 8'h80, 8'h99, 8'hF0, 8'h9F, 8'h7F, 8'h25, 8'h34, 8'h5A};
    send_text();
    // decoded nul ends the text early, rest ignored
    text_q = '{8'h25, 8'h30, 8'h30, 8'h41, 8'h42};
    send_text();
    // lone percent at the end
    text_q = '{8'h25};
    send_text();
    wait_drain();

    start = items_sent;
    done_cnt = 0;
    while (done_cnt < RANDOM_ITEMS) begin
      gaps_on   = (done_cnt < RANDOM_ITEMS - 50) && ($urandom_range(0, 2) != 0);
      stalls_on = (done_cnt < RANDOM_ITEMS - 50) && ($urandom_range(0, 2) != 0);
      if (!paused && done_cnt >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drain();
      end
      text_q.delete();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) add_token();
      end
      send_text();
      done_cnt = items_sent - start;
    end

    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("sent %0d texts of %0d bytes with idle and stall bursts; %0d results checked",
             texts_sent, items_sent, checked);
    if (mismatches == 0) begin
      $display("url_decode_accent_fold verification clean");
    end else begin
      $display("url_decode_accent_fold verification failed");
    end
    $finish;
  end

endmodule
